FILE: rtl/lsh_pkg.sv
// shared types, constants and frame table for the link set-up handshake
package lsh_pkg;

    localparam int CMD_DEPTH = 4;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ADDR_BYTE = 8'h03;
    localparam logic [7:0] SET_CTRL  = 8'h03;
    localparam logic [7:0] UA_CTRL   = 8'h07;

    localparam logic [2:0] LAST_BEAT = 3'd4;

    typedef enum logic [1:0] {
        OP_START = 2'd0,
        OP_BYTE  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_CONN = 2'd2,
        PH_FAIL = 2'd3
    } phase_t;

    typedef struct packed {
        logic [15:0] timeout_ticks;
        logic [3:0]  max_attempts;
    } cfg_t;

    // one command from the front: send a frame or a single plain word
    typedef struct packed {
        logic   frame;
        phase_t status;
    } cmd_t;

    function automatic logic [7:0] set_frame_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = FLAG_BYTE;
            3'd1:    b = ADDR_BYTE;
            3'd2:    b = SET_CTRL;
            3'd3:    b = ADDR_BYTE ^ SET_CTRL;
            default: b = FLAG_BYTE;
        endcase
        return b;
    endfunction

endpackage

FILE: rtl/link_setup_handshake_core.sv
// top level of the link set-up handshake with its configuration registers
//
// Transmitter side of the SET/UA link set-up. Items go in through push/full
// with an operation code: start, received byte, one time tick or none. A start, and
// every timeout below the attempt limit, makes five result words carrying the
// SET frame 7E 03 03 00 7E; any other item makes one word with no byte. Every
// word carries the phase after its item, and the final word of an item has
// last set. The front takes one item per cycle while the command queue has
// room; the back sequencer drains one result word per cycle while pop is
// held. Registers: timeout_ticks at byte address 0, max_attempts at byte
// address 4; a zero value acts as one.
module link_setup_handshake_core #(
    parameter int CMD_DEPTH = lsh_pkg::CMD_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        push,
    output logic        full,
    input  logic [1:0]  operation,
    input  logic [7:0]  rx_byte,
    output logic        empty,
    input  logic        pop,
    output logic        tx_valid,
    output logic [7:0]  tx_byte,
    output logic        last,
    output logic [1:0]  status
);

    logic [15:0]   timeout_reg;
    logic [3:0]    attempts_reg;
    lsh_pkg::cfg_t cfg;
    lsh_pkg::cmd_t front_cmd, back_cmd;
    logic          accept, cmd_rd, cmd_empty, cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            timeout_reg  <= 16'd3;
            attempts_reg <= 4'd3;
        end
        else if (cfg_wr)
        begin
            if (paddr[2])
                attempts_reg <= pwdata[3:0];
            else
                timeout_reg <= pwdata[15:0];
        end
    end

    assign prdata = paddr[2] ? {28'd0, attempts_reg} : {16'd0, timeout_reg};

    assign cfg.timeout_ticks = timeout_reg;
    assign cfg.max_attempts  = attempts_reg;

    assign accept = push && !full;

    lsh_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .operation (operation),
        .rx_byte   (rx_byte),
        .cfg       (cfg),
        .cmd       (front_cmd)
    );

    lsh_cmd_fifo #(
        .DEPTH (CMD_DEPTH)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (accept),
        .wr_data (front_cmd),
        .full    (full),
        .rd_en   (cmd_rd),
        .rd_data (back_cmd),
        .empty   (cmd_empty)
    );

    lsh_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (back_cmd),
        .cmd_empty (cmd_empty),
        .cmd_rd    (cmd_rd),
        .empty     (empty),
        .pop       (pop),
        .tx_valid  (tx_valid),
        .tx_byte   (tx_byte),
        .last      (last),
        .status    (status)
    );

endmodule

FILE: rtl/lsh_front.sv
// front part: accepts items, runs the ua parser, timeout and attempt counters
module lsh_front (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           accept,
    input  logic [1:0]     operation,
    input  logic [7:0]     rx_byte,
    input  lsh_pkg::cfg_t  cfg,
    output lsh_pkg::cmd_t  cmd
);

    typedef enum logic [2:0] {
        PS_START = 3'd0,
        PS_FLAG  = 3'd1,
        PS_A     = 3'd2,
        PS_C     = 3'd3,
        PS_BCC   = 3'd4,
        PS_STOP  = 3'd5
    } parse_t;

    lsh_pkg::phase_t phase_reg, phase_next;
    parse_t          parse_reg, parse_next, parse_step;
    logic [15:0]     tick_reg, tick_next, tick_inc, limit;
    logic [3:0]      attempt_reg, attempt_next, attempt_inc, tries;
    logic            frame;

    always_comb
    begin
        case (parse_reg)
            PS_START: parse_step = (rx_byte == lsh_pkg::FLAG_BYTE) ? PS_FLAG : PS_START;
            PS_BCC:   parse_step = (rx_byte == lsh_pkg::FLAG_BYTE) ? PS_STOP : PS_START;
            PS_STOP:  parse_step = PS_STOP;
            PS_FLAG:
            begin
                if (rx_byte == lsh_pkg::FLAG_BYTE)
                    parse_step = PS_FLAG;
                else
                    parse_step = (rx_byte == lsh_pkg::ADDR_BYTE) ? PS_A : PS_START;
            end
            PS_A:
            begin
                if (rx_byte == lsh_pkg::FLAG_BYTE)
                    parse_step = PS_FLAG;
                else
                    parse_step = (rx_byte == lsh_pkg::UA_CTRL) ? PS_C : PS_START;
            end
            PS_C:
            begin
                if (rx_byte == lsh_pkg::FLAG_BYTE)
                    parse_step = PS_FLAG;
                else if (rx_byte == (lsh_pkg::ADDR_BYTE ^ lsh_pkg::UA_CTRL))
                    parse_step = PS_BCC;
                else
                    parse_step = PS_START;
            end
            default:  parse_step = PS_START;
        endcase
    end

    // zero settings behave as one
    assign limit       = (cfg.timeout_ticks == 16'd0) ? 16'd1 : cfg.timeout_ticks;
    assign tries       = (cfg.max_attempts == 4'd0) ? 4'd1 : cfg.max_attempts;
    assign tick_inc    = tick_reg + 16'd1;
    assign attempt_inc = attempt_reg + 4'd1;

    always_comb
    begin
        phase_next   = phase_reg;
        parse_next   = parse_reg;
        tick_next    = tick_reg;
        attempt_next = attempt_reg;
        frame        = 1'b0;
        case (lsh_pkg::op_t'(operation))
            lsh_pkg::OP_START:
            begin
                phase_next   = lsh_pkg::PH_WAIT;
                parse_next   = PS_START;
                tick_next    = 16'd0;
                attempt_next = 4'd0;
                frame        = 1'b1;
            end
            lsh_pkg::OP_BYTE:
            begin
                if (phase_reg == lsh_pkg::PH_WAIT)
                begin
                    parse_next = parse_step;
                    if (parse_step == PS_STOP)
                        phase_next = lsh_pkg::PH_CONN;
                end
            end
            lsh_pkg::OP_TICK:
            begin
                if (phase_reg == lsh_pkg::PH_WAIT)
                begin
                    tick_next = tick_inc;
                    if (tick_inc >= limit)
                    begin
                        tick_next    = 16'd0;
                        attempt_next = attempt_inc;
                        if (attempt_inc >= tries)
                            phase_next = lsh_pkg::PH_FAIL;
                        else
                            frame = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign cmd.frame  = frame;
    assign cmd.status = phase_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= lsh_pkg::PH_IDLE;
            parse_reg   <= PS_START;
            tick_reg    <= 16'd0;
            attempt_reg <= 4'd0;
        end
        else if (accept)
        begin
            phase_reg   <= phase_next;
            parse_reg   <= parse_next;
            tick_reg    <= tick_next;
            attempt_reg <= attempt_next;
        end
    end

endmodule

FILE: rtl/lsh_cmd_fifo.sv
// short command queue between the front and the back
module lsh_cmd_fifo #(
    parameter int DEPTH = lsh_pkg::CMD_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  lsh_pkg::cmd_t wr_data,
    output logic          full,
    input  logic          rd_en,
    output lsh_pkg::cmd_t rd_data,
    output logic          empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    lsh_pkg::cmd_t    mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_wr, do_rd;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign do_wr   = wr_en && !full;
    assign do_rd   = rd_en && !empty;
    assign rd_data = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
            if (do_wr && !do_rd)
                count_reg <= count_reg + CNT_W'(1);
            else if (do_rd && !do_wr)
                count_reg <= count_reg - CNT_W'(1);
        end
    end

endmodule

FILE: rtl/lsh_back.sv
// back part: expands each command into result words, one word per cycle while pop is held
module lsh_back (
    input  logic          clk,
    input  logic          rst_n,
    input  lsh_pkg::cmd_t cmd,
    input  logic          cmd_empty,
    output logic          cmd_rd,
    output logic          empty,
    input  logic          pop,
    output logic          tx_valid,
    output logic [7:0]    tx_byte,
    output logic          last,
    output logic [1:0]    status
);

    logic            cur_valid_reg;
    logic            frame_reg;
    lsh_pkg::phase_t status_reg;
    logic [2:0]      beat_reg;
    logic            word_done;

    assign empty     = !cur_valid_reg;
    assign tx_valid  = frame_reg;
    assign tx_byte   = frame_reg ? lsh_pkg::set_frame_byte(beat_reg) : 8'h00;
    assign last      = !frame_reg || (beat_reg == lsh_pkg::LAST_BEAT);
    assign status    = status_reg;
    assign word_done = cur_valid_reg && pop;

    // fetch the next command when idle or as the final word leaves
    assign cmd_rd = !cmd_empty && (!cur_valid_reg || (word_done && last));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_valid_reg <= 1'b0;
        else if (cmd_rd)
            cur_valid_reg <= 1'b1;
        else if (word_done && last)
            cur_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd_rd)
        begin
            frame_reg  <= cmd.frame;
            status_reg <= cmd.status;
            beat_reg   <= 3'd0;
        end
        else if (word_done && !last)
            beat_reg <= beat_reg + 3'd1;
    end

endmodule

FILE: test/lsh_handshake_checker.sv
// checker for the link set-up handshake: watches the ports, predicts and compares result words
`timescale 1ns / 100ps

module lsh_handshake_checker #(
    parameter logic [2:0] TIMEOUT_ADDR  = 3'd0,
    parameter logic [2:0] ATTEMPTS_ADDR = 3'd4
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        pready,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        push,
    input  logic        full,
    input  logic [1:0]  operation,
    input  logic [7:0]  rx_byte,
    input  logic        empty,
    input  logic        pop,
    input  logic        tx_valid,
    input  logic [7:0]  tx_byte,
    input  logic        last,
    input  logic [1:0]  status,
    output int          outstanding,
    output int          fail_count
);

    typedef enum logic [2:0] {
        PS_START,
        PS_FLAG,
        PS_ADDR,
        PS_CTRL,
        PS_BCC,
        PS_STOP
    } parse_t;

    typedef struct packed {
        logic            tx_valid;
        logic [7:0]      tx_byte;
        logic            last;
        lsh_pkg::phase_t status;
    } tx_word_t;

    localparam logic [39:0] SET_FRAME =
        {lsh_pkg::FLAG_BYTE, lsh_pkg::ADDR_BYTE, lsh_pkg::SET_CTRL,
         lsh_pkg::ADDR_BYTE ^ lsh_pkg::SET_CTRL, lsh_pkg::FLAG_BYTE};

    tx_word_t        tx_words_due[$];
    int              due_count      = 0;
    int              mismatch_count = 0;

    logic [15:0]     cfg_timeout    = 16'd3;
    logic [3:0]      cfg_attempts   = 4'd3;
    lsh_pkg::phase_t link_phase     = lsh_pkg::PH_IDLE;
    parse_t          parse_pos      = PS_START;
    logic [15:0]     tick_count     = 16'd0;
    logic [3:0]      attempt_count  = 4'd0;

    assign outstanding = due_count;
    assign fail_count  = mismatch_count + due_count;

    function automatic parse_t next_parse(parse_t st, logic [7:0] b);
        parse_t nx;
        nx = PS_START;
        if (st == PS_START)
            nx = (b == lsh_pkg::FLAG_BYTE) ? PS_FLAG : PS_START;
        else if (st == PS_BCC)
            nx = (b == lsh_pkg::FLAG_BYTE) ? PS_STOP : PS_START;
        else if (st == PS_STOP)
            nx = PS_STOP;
        else if (b == lsh_pkg::FLAG_BYTE)
            nx = PS_FLAG;   // resync on a flag in mid-frame
        else if (st == PS_FLAG)
            nx = (b == lsh_pkg::ADDR_BYTE) ? PS_ADDR : PS_START;
        else if (st == PS_ADDR)
            nx = (b == lsh_pkg::UA_CTRL) ? PS_CTRL : PS_START;
        else if (st == PS_CTRL)
            nx = (b == (lsh_pkg::ADDR_BYTE ^ lsh_pkg::UA_CTRL)) ? PS_BCC : PS_START;
        return nx;
    endfunction

    task automatic queue_words(bit frame);
        tx_word_t w;
        int       k;
        if (frame)
        begin
            for (k = 0; k < 5; k++)
            begin
                w.tx_valid = 1'b1;
                w.tx_byte  = SET_FRAME[39 - 8*k -: 8];
                w.last     = (k == 4);
                w.status   = link_phase;
                tx_words_due.push_back(w);
            end
        end
        else
        begin
            w.tx_valid = 1'b0;
            w.tx_byte  = 8'h00;
            w.last     = 1'b1;
            w.status   = link_phase;
            tx_words_due.push_back(w);
        end
        due_count = tx_words_due.size();
    endtask

    task automatic advance_link(lsh_pkg::op_t op, logic [7:0] b);
        logic [15:0] limit;
        logic [3:0]  tries;
        bit          frame;
        frame = 1'b0;
        limit = (cfg_timeout == 16'd0) ? 16'd1 : cfg_timeout;
        tries = (cfg_attempts == 4'd0) ? 4'd1 : cfg_attempts;
        case (op)
            lsh_pkg::OP_START:
            begin
                link_phase    = lsh_pkg::PH_WAIT;
                parse_pos     = PS_START;
                tick_count    = 16'd0;
                attempt_count = 4'd0;
                frame         = 1'b1;
            end
            lsh_pkg::OP_BYTE:
            begin
                if (link_phase == lsh_pkg::PH_WAIT)
                begin
                    parse_pos = next_parse(parse_pos, b);
                    if (parse_pos == PS_STOP)
                        link_phase = lsh_pkg::PH_CONN;
                end
            end
            lsh_pkg::OP_TICK:
            begin
                if (link_phase == lsh_pkg::PH_WAIT)
                begin
                    tick_count = tick_count + 16'd1;
                    if (tick_count >= limit)
                    begin
                        tick_count    = 16'd0;
                        attempt_count = attempt_count + 4'd1;
                        // no resend on the final timeout
                        if (attempt_count >= tries)
                            link_phase = lsh_pkg::PH_FAIL;
                        else
                            frame = 1'b1;
                    end
                end
            end
            default: ;
        endcase
        queue_words(frame);
    endtask

    task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        tx_word_t want;
        if (!rst_n)
        begin
            tx_words_due.delete();
            due_count     = 0;
            cfg_timeout   = 16'd3;
            cfg_attempts  = 4'd3;
            link_phase    = lsh_pkg::PH_IDLE;
            parse_pos     = PS_START;
            tick_count    = 16'd0;
            attempt_count = 4'd0;
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == TIMEOUT_ADDR)
                    cfg_timeout = pwdata[15:0];
                else if (paddr == ATTEMPTS_ADDR)
                    cfg_attempts = pwdata[3:0];
            end
            if (pop && !empty)
            begin
                if (tx_words_due.size() == 0)
                begin
                    $error("result word with nothing expected: tx_valid %0d tx_byte 0x%0h",
                           tx_valid, tx_byte);
                    mismatch_count++;
                end
                else
                begin
                    want = tx_words_due.pop_front();
                    due_count = tx_words_due.size();
                    check_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid));
                    check_field("tx_byte", want.tx_byte, tx_byte);
                    check_field("last", 8'(want.last), 8'(last));
                    check_field("status", 8'(want.status), 8'(status));
                end
            end
            if (push && !full)
                advance_link(lsh_pkg::op_t'(operation), rx_byte);
        end
    end

endmodule

FILE: test/tb.sv
// testbench top for the link set-up handshake: stimulus, register setup and verdict
`timescale 1ns / 100ps

module tb;

    localparam int          HALF_PERIOD   = 10;
    localparam int          LIMIT_NS      = 4_000_000;
    localparam int          TAIL_CYCLES   = 12;
    localparam logic [2:0]  TIMEOUT_ADDR  = 3'd0;
    localparam logic [2:0]  ATTEMPTS_ADDR = 3'd4;
    localparam logic [39:0] UA_FRAME      =
        {lsh_pkg::FLAG_BYTE, lsh_pkg::ADDR_BYTE, lsh_pkg::UA_CTRL,
         lsh_pkg::ADDR_BYTE ^ lsh_pkg::UA_CTRL, lsh_pkg::FLAG_BYTE};

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = 3'd0;
    logic [31:0] pwdata   = 32'd0;
    logic [31:0] prdata;
    logic        pready;
    logic        push     = 1'b0;
    logic        full;
    logic [1:0]  operation = 2'd0;
    logic [7:0]  rx_byte  = 8'd0;
    logic        empty;
    logic        pop      = 1'b0;
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic [1:0]  status;

    int outstanding;
    int fail_count;
    int send_idle_pct = 14;
    int recv_idle_pct = 46;
    int items_sent    = 0;
    int cur_timeout   = 3;
    int cur_attempts  = 3;

    always #(HALF_PERIOD) clk = ~clk;

    link_setup_handshake_core i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .push      (push),
        .full      (full),
        .operation (operation),
        .rx_byte   (rx_byte),
        .empty     (empty),
        .pop       (pop),
        .tx_valid  (tx_valid),
        .tx_byte   (tx_byte),
        .last      (last),
        .status    (status)
    );

    lsh_handshake_checker #(
        .TIMEOUT_ADDR  (TIMEOUT_ADDR),
        .ATTEMPTS_ADDR (ATTEMPTS_ADDR)
    ) i_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .pready      (pready),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .push        (push),
        .full        (full),
        .operation   (operation),
        .rx_byte     (rx_byte),
        .empty       (empty),
        .pop         (pop),
        .tx_valid    (tx_valid),
        .tx_byte     (tx_byte),
        .last        (last),
        .status      (status),
        .outstanding (outstanding),
        .fail_count  (fail_count)
    );

    // receiver side stalls at random
    always @(posedge clk)
        pop <= ($urandom_range(99) >= recv_idle_pct);

    task automatic send_item(lsh_pkg::op_t op, logic [7:0] b);
        while ($urandom_range(99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push      <= 1'b1;
        operation <= op;
        rx_byte   <= b;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    // hold off until every expected word has come out
    task automatic settle_link();
        push <= 1'b0;
        do
            @(posedge clk);
        while (outstanding != 0);
        repeat (TAIL_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [2:0] addr, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // upper bits are random: only the low bits of each register count
    task automatic set_limits(int timeout, int attempts);
        write_reg(TIMEOUT_ADDR, ($urandom & 32'hFFFF_0000) | (timeout & 32'hFFFF));
        write_reg(ATTEMPTS_ADDR, ($urandom & 32'hFFFF_FFF0) | (attempts & 32'hF));
        cur_timeout  = timeout;
        cur_attempts = attempts;
    endtask

    // mostly start sessions with random noise, then a reply or ticks; some bare random items
    task automatic run_traffic(int n);
        int target;
        int pick;
        int bad_at;
        int budget;
        int k;
        target = items_sent + n;
        budget = (cur_timeout == 0 ? 1 : cur_timeout) * (cur_attempts == 0 ? 1 : cur_attempts) + 1;
        if (budget > 12)
            budget = 12;
        while (items_sent < target)
        begin
            pick = $urandom_range(99);
            if (pick < 15)
                send_item(lsh_pkg::op_t'($urandom_range(3)), 8'($urandom_range(255)));
            else
            begin
                send_item(lsh_pkg::OP_START, 8'($urandom_range(255)));
                repeat ($urandom_range(2))
                    send_item($urandom_range(1) ? lsh_pkg::OP_BYTE : lsh_pkg::OP_TICK,
                              8'($urandom_range(255)));
                if (pick < 70)
                begin
                    bad_at = ($urandom_range(3) == 0) ? $urandom_range(4) : 5;
                    for (k = 0; k < 5; k++)
                    begin
                        if ($urandom_range(9) == 0)
                            send_item(lsh_pkg::OP_TICK, 8'($urandom_range(255)));
                        send_item(lsh_pkg::OP_BYTE, (k == bad_at) ? 8'($urandom_range(255))
                                                                  : UA_FRAME[39 - 8*k -: 8]);
                    end
                end
                else
                begin
                    repeat ($urandom_range(1, budget))
                        send_item(lsh_pkg::OP_TICK, 8'($urandom_range(255)));
                end
            end
        end
    endtask

    initial
    begin
        int k;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // nothing started yet: all ignored
        send_item(lsh_pkg::OP_TICK, 8'h00);
        send_item(lsh_pkg::OP_BYTE, lsh_pkg::FLAG_BYTE);
        send_item(lsh_pkg::OP_NONE, 8'hFF);
        // clean reply gets connected, then ticks are ignored
        send_item(lsh_pkg::OP_START, 8'hFF);
        for (k = 0; k < 5; k++)
            send_item(lsh_pkg::OP_BYTE, UA_FRAME[39 - 8*k -: 8]);
        send_item(lsh_pkg::OP_TICK, 8'h00);
        // restart from connected, flag resync, bad check byte
        send_item(lsh_pkg::OP_START, 8'h00);
        send_item(lsh_pkg::OP_BYTE, lsh_pkg::FLAG_BYTE);
        send_item(lsh_pkg::OP_BYTE, lsh_pkg::ADDR_BYTE);
        send_item(lsh_pkg::OP_BYTE, lsh_pkg::FLAG_BYTE);
        send_item(lsh_pkg::OP_BYTE, lsh_pkg::ADDR_BYTE);
        send_item(lsh_pkg::OP_BYTE, lsh_pkg::UA_CTRL);
        send_item(lsh_pkg::OP_BYTE, 8'h05);
        send_item(lsh_pkg::OP_NONE, 8'h00);
        // two resends, then failure without a resend
        repeat (9) send_item(lsh_pkg::OP_TICK, 8'hFF);
        send_item(lsh_pkg::OP_BYTE, lsh_pkg::FLAG_BYTE);

        run_traffic(25);
        settle_link();
        set_limits(1, 1);
        run_traffic(10);
        settle_link();
        set_limits(0, 0);
        run_traffic(8);
        settle_link();

        send_idle_pct = 46;
        recv_idle_pct = 14;
        set_limits(65535, 15);
        run_traffic(15);
        settle_link();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_limits($urandom_range(1, 4), $urandom_range(2, 5));
        run_traffic(30);
        settle_link();

        if (fail_count == 0)
            $display("link_setup_handshake_core verification clean");
        else
            $display("link_setup_handshake_core verification failed");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("link_setup_handshake_core verification failed");
        $finish;
    end

endmodule
